// ----- rtl/touch_zone_button_debouncer_assert.svh -----
// Assertion macros shared by the touch zone debouncer RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef TOUCH_ZONE_BUTTON_DEBOUNCER_ASSERT_SVH
`define TOUCH_ZONE_BUTTON_DEBOUNCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define TZB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define TZB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TZB_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TZB_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/tzb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tzb_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 320;
  localparam int unsigned SCREEN_HEIGHT_DEF = 240;
  localparam int unsigned BAR_HEIGHT_DEF    = 50;

  localparam int unsigned RAW_W      = 12;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned PROD_W     = 2 * COORD_W;
  localparam int unsigned DIV_STEPS  = PROD_W;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SETTLE_W   = 16;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned SX_W       = 9;
  localparam int unsigned SY_W       = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_X_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_X_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_LOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_FLOOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_MS      = 3'd5;

  localparam logic [RAW_W-1:0]    CAL_LOW_RST  = 12'd200;
  localparam logic [RAW_W-1:0]    CAL_HIGH_RST = 12'd3800;
  localparam logic [RAW_W-1:0]    FLOOR_RST    = 12'd50;
  localparam logic [SETTLE_W-1:0] SETTLE_RST   = 16'd60;

  localparam logic [CODE_W-1:0] BTN_NONE       = 3'd0;
  localparam logic [CODE_W-1:0] BTN_LEFT       = 3'd1;
  localparam logic [CODE_W-1:0] BTN_OK         = 3'd2;
  localparam logic [CODE_W-1:0] BTN_RIGHT      = 3'd3;
  localparam logic [CODE_W-1:0] BTN_LEFT_RIGHT = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_STORE,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/tzb_sample_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tzb_sample_if;
  logic                       valid;
  logic                       ready;
  logic                       panel_touched;
  logic [tzb_pkg::RAW_W-1:0]  raw_x;
  logic [tzb_pkg::RAW_W-1:0]  raw_y;
  logic [tzb_pkg::RAW_W-1:0]  raw_pressure;
  logic [tzb_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, panel_touched, raw_x, raw_y, raw_pressure, now_ms,
                  input ready);
  modport sink (input valid, panel_touched, raw_x, raw_y, raw_pressure, now_ms,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/tzb_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tzb_result_if;
  logic                       valid;
  logic                       ready;
  logic                       press_fired;
  logic [tzb_pkg::CODE_W-1:0] pressed_button;
  logic [tzb_pkg::CODE_W-1:0] held_button;
  logic [tzb_pkg::SX_W-1:0]   screen_x;
  logic [tzb_pkg::SY_W-1:0]   screen_y;
  logic                       has_position;
  logic                       finger_down;

  modport source (output valid, press_fired, pressed_button, held_button, screen_x,
                  screen_y, has_position, finger_down, input ready);
  modport sink (input valid, press_fired, pressed_button, held_button, screen_x,
                screen_y, has_position, finger_down, output ready);
endinterface

`default_nettype wire

// ----- rtl/tzb_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tzb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tzb_pkg::CFG_IDX_W-1:0]  index;
  logic [tzb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/touch_zone_button_debouncer.sv -----
// Channel  Role  Payload
// -------  ----  ------------------------------------------------------------
// sample   sink  panel_touched, raw_x, raw_y, raw_pressure, now_ms
// result   src   press_fired, pressed_button, held_button, screen_x, screen_y,
//                has_position, finger_down
// cfg      sink  index (3 bits), data (16 bits); always ready
//
// A touched sample with valid pressure goes through setup, multiply, divide and store
// for the x axis and then for the y axis: one restoring divider, one quotient bit per
// cycle, is shared by the two axes in turn. Other samples go straight to the last
// step. The next sample is accepted in the cycle after the beat is written; while
// the result register still holds an untaken beat, the block waits in its last step.
// Reset is synchronous and clears the control, debounce and configuration state.
`timescale 1ns / 1ps
`default_nettype none

`include "touch_zone_button_debouncer_assert.svh"

module touch_zone_button_debouncer #(
  parameter int unsigned SCREEN_WIDTH  = tzb_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = tzb_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned BAR_HEIGHT    = tzb_pkg::BAR_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tzb_sample_if.sink    sample,
  tzb_result_if.source  result,
  tzb_cfg_if.sink       cfg
);

  localparam int unsigned CW    = tzb_pkg::COORD_W;
  localparam int unsigned PW    = tzb_pkg::PROD_W;
  localparam int unsigned RW    = tzb_pkg::RAW_W;
  localparam int unsigned TW    = tzb_pkg::TIME_W;
  localparam int unsigned CNT_W = $clog2(tzb_pkg::DIV_STEPS);

  localparam logic [CW-1:0] TOP_X = CW'(SCREEN_WIDTH - 1);
  localparam logic [CW-1:0] TOP_Y = CW'(SCREEN_HEIGHT - 1);
  localparam int            BAR_TOP = int'(SCREEN_HEIGHT) - int'(BAR_HEIGHT);
  localparam bit            BAR_ALL = (BAR_TOP <= 0);
  localparam logic [CW-1:0] BAR_TOP_U = CW'((BAR_TOP > 0) ? BAR_TOP : 0);
  localparam logic [CW-1:0] ZONE_1 = CW'(SCREEN_WIDTH / 4);
  localparam logic [CW-1:0] ZONE_2 = CW'(2 * (SCREEN_WIDTH / 4));
  localparam logic [CW-1:0] ZONE_3 = CW'(3 * (SCREEN_WIDTH / 4));
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tzb_pkg::DIV_STEPS - 1);

  // Configuration registers.
  logic [RW-1:0]                cal_x_low;
  logic [RW-1:0]                cal_x_high;
  logic [RW-1:0]                cal_y_low;
  logic [RW-1:0]                cal_y_high;
  logic [RW-1:0]                pressure_floor;
  logic [tzb_pkg::SETTLE_W-1:0] settle_ms;

  // Latched sample.
  logic          s_touched;
  logic          s_press_ok;
  logic [RW-1:0] s_raw_x;
  logic [RW-1:0] s_raw_y;
  logic [TW-1:0] s_now;

  // Shared scaling unit.
  tzb_pkg::state_t state;
  tzb_pkg::state_t state_next;
  logic             axis;
  logic [CW-1:0]    mag_num;
  logic [CW-1:0]    mag_den;
  logic             zero_res;
  logic [PW-1:0]    quo;
  logic [CW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic [CW-1:0]    res_x;
  logic [CW-1:0]    res_y;

  // Debounce and position state.
  logic [tzb_pkg::CODE_W-1:0] recent_code;
  logic [TW-1:0]              change_time;
  logic [tzb_pkg::CODE_W-1:0] stable_code;
  logic                       already_fired;
  logic [tzb_pkg::SX_W-1:0]   saved_x;
  logic [tzb_pkg::SY_W-1:0]   saved_y;
  logic                       position_known;

  logic sample_ready;
  logic fin_go;

  assign cfg.ready = 1'b1;
  assign sample.ready = sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_x_low      <= tzb_pkg::CAL_LOW_RST;
      cal_x_high     <= tzb_pkg::CAL_HIGH_RST;
      cal_y_low      <= tzb_pkg::CAL_LOW_RST;
      cal_y_high     <= tzb_pkg::CAL_HIGH_RST;
      pressure_floor <= tzb_pkg::FLOOR_RST;
      settle_ms      <= tzb_pkg::SETTLE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        tzb_pkg::REG_CAL_X_LOW:      cal_x_low      <= cfg.data[RW-1:0];
        tzb_pkg::REG_CAL_X_HIGH:     cal_x_high     <= cfg.data[RW-1:0];
        tzb_pkg::REG_CAL_Y_LOW:      cal_y_low      <= cfg.data[RW-1:0];
        tzb_pkg::REG_CAL_Y_HIGH:     cal_y_high     <= cfg.data[RW-1:0];
        tzb_pkg::REG_PRESSURE_FLOOR: pressure_floor <= cfg.data[RW-1:0];
        tzb_pkg::REG_SETTLE_MS:      settle_ms      <= cfg.data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tzb_pkg::ST_IDLE: begin
        if (sample.valid) begin
          if (sample.panel_touched && (sample.raw_pressure >= pressure_floor)) begin
            state_next = tzb_pkg::ST_SETUP;
          end else begin
            state_next = tzb_pkg::ST_FINISH;
          end
        end
      end
      tzb_pkg::ST_SETUP: state_next = tzb_pkg::ST_MUL;
      tzb_pkg::ST_MUL:   state_next = tzb_pkg::ST_DIV;
      tzb_pkg::ST_DIV: begin
        if (cnt == CNT_LAST) begin
          state_next = tzb_pkg::ST_STORE;
        end
      end
      tzb_pkg::ST_STORE: begin
        state_next = axis ? tzb_pkg::ST_FINISH : tzb_pkg::ST_SETUP;
      end
      tzb_pkg::ST_FINISH: begin
        if (!result.valid || result.ready) begin
          state_next = tzb_pkg::ST_IDLE;
        end
      end
      default: state_next = tzb_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    sample_ready = 1'b0;
    fin_go       = 1'b0;
    case (state)
      tzb_pkg::ST_IDLE:   sample_ready = 1'b1;
      tzb_pkg::ST_FINISH: fin_go = !result.valid || result.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tzb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Axis operands for the shared unit.
  logic [RW-1:0] op_raw;
  logic [RW-1:0] op_lo;
  logic [RW-1:0] op_hi;
  logic [CW:0]   op_num;
  logic [CW:0]   op_den;
  logic [CW:0]   num_abs;
  logic [CW:0]   den_abs;
  logic [CW-1:0] top_sel;
  logic [CW:0]   rem_sh;
  logic          rem_ge;
  logic [CW:0]   rem_sub;
  logic [CW-1:0] clamp_val;

  always_comb begin
    op_raw    = axis ? s_raw_y : s_raw_x;
    op_lo     = axis ? cal_y_low : cal_x_low;
    op_hi     = axis ? cal_y_high : cal_x_high;
    top_sel   = axis ? TOP_Y : TOP_X;
    op_num    = {1'b0, op_raw} - {1'b0, op_lo};
    op_den    = {1'b0, op_hi} - {1'b0, op_lo};
    num_abs   = op_num[CW] ? (~op_num + 1'b1) : op_num;
    den_abs   = op_den[CW] ? (~op_den + 1'b1) : op_den;
    rem_sh    = {rem, quo[PW-1]};
    rem_ge    = rem_sh >= {1'b0, mag_den};
    rem_sub   = rem_sh - {1'b0, mag_den};
    if (zero_res) begin
      clamp_val = '0;
    end else if (quo > {{(PW-CW){1'b0}}, top_sel}) begin
      clamp_val = top_sel;
    end else begin
      clamp_val = quo[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tzb_pkg::ST_IDLE: begin
        if (sample.valid) begin
          s_touched  <= sample.panel_touched;
          s_press_ok <= sample.raw_pressure >= pressure_floor;
          s_raw_x    <= sample.raw_x;
          s_raw_y    <= sample.raw_y;
          s_now      <= sample.now_ms;
          axis       <= 1'b0;
        end
      end
      tzb_pkg::ST_SETUP: begin
        mag_num  <= num_abs[CW-1:0];
        mag_den  <= den_abs[CW-1:0];
        zero_res <= (op_den == '0) || (op_num == '0) || (op_num[CW] != op_den[CW]);
      end
      tzb_pkg::ST_MUL: begin
        quo <= {{(PW-CW){1'b0}}, mag_num} * {{(PW-CW){1'b0}}, top_sel};
        rem <= '0;
        cnt <= '0;
      end
      tzb_pkg::ST_DIV: begin
        rem <= rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
        quo <= {quo[PW-2:0], rem_ge};
        cnt <= cnt + 1'b1;
      end
      tzb_pkg::ST_STORE: begin
        if (axis) begin
          res_y <= clamp_val;
        end else begin
          res_x <= clamp_val;
          axis  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Debounce update, applied when the result beat is written.
  logic                       touch_ok;
  logic                       in_bar;
  logic [tzb_pkg::CODE_W-1:0] zone;
  logic [tzb_pkg::CODE_W-1:0] code;
  logic [tzb_pkg::CODE_W-1:0] rc_new;
  logic [TW-1:0]              ct_new;
  logic                       af_mid;
  logic [TW-1:0]              elapsed;
  logic [tzb_pkg::CODE_W-1:0] st_mid;
  logic [tzb_pkg::CODE_W-1:0] st_new;
  logic                       af_new;
  logic                       fire;
  logic [tzb_pkg::CODE_W-1:0] fired_code;

  always_comb begin
    touch_ok = s_touched && s_press_ok;
    in_bar   = BAR_ALL || (res_y >= BAR_TOP_U);
    if (!in_bar) begin
      zone = tzb_pkg::BTN_NONE;
    end else if (res_x < ZONE_1) begin
      zone = tzb_pkg::BTN_LEFT;
    end else if (res_x < ZONE_2) begin
      zone = tzb_pkg::BTN_OK;
    end else if (res_x < ZONE_3) begin
      zone = tzb_pkg::BTN_RIGHT;
    end else begin
      zone = tzb_pkg::BTN_LEFT_RIGHT;
    end
    code = touch_ok ? zone : tzb_pkg::BTN_NONE;

    if (code != recent_code) begin
      rc_new = code;
      ct_new = s_now;
      af_mid = 1'b0;
    end else begin
      rc_new = recent_code;
      ct_new = change_time;
      af_mid = already_fired;
    end
    elapsed = s_now - ct_new;
    st_mid  = (elapsed > {{(TW-tzb_pkg::SETTLE_W){1'b0}}, settle_ms}) ? rc_new : stable_code;

    fire       = 1'b0;
    fired_code = tzb_pkg::BTN_NONE;
    st_new     = st_mid;
    af_new     = af_mid;
    if ((st_mid != tzb_pkg::BTN_NONE) && !af_mid) begin
      fire       = 1'b1;
      fired_code = st_mid;
      af_new     = 1'b1;
    end else if (rc_new == tzb_pkg::BTN_NONE) begin
      af_new = 1'b0;
      st_new = tzb_pkg::BTN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_code    <= tzb_pkg::BTN_NONE;
      change_time    <= '0;
      stable_code    <= tzb_pkg::BTN_NONE;
      already_fired  <= 1'b0;
      saved_x        <= '0;
      saved_y        <= '0;
      position_known <= 1'b0;
    end else if (fin_go) begin
      recent_code   <= rc_new;
      change_time   <= ct_new;
      stable_code   <= st_new;
      already_fired <= af_new;
      if (touch_ok) begin
        saved_x        <= res_x[tzb_pkg::SX_W-1:0];
        saved_y        <= res_y[tzb_pkg::SY_W-1:0];
        position_known <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fin_go) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      result.press_fired    <= fire;
      result.pressed_button <= fired_code;
      result.held_button    <= rc_new;
      result.screen_x       <= touch_ok ? res_x[tzb_pkg::SX_W-1:0] : saved_x;
      result.screen_y       <= touch_ok ? res_y[tzb_pkg::SY_W-1:0] : saved_y;
      result.has_position   <= touch_ok || position_known;
      result.finger_down    <= s_touched;
    end
  end

  `TZB_ASSERT_NXT(a_busy_after_accept, clk, rst, sample.valid && sample_ready,
    !sample_ready, "sample accepted while busy")
  `TZB_ASSERT_IMP(a_fire_has_code, clk, rst, result.valid,
    result.press_fired == (result.pressed_button != tzb_pkg::BTN_NONE),
    "press flag and code disagree")
  `TZB_ASSERT_NXT(a_taken_drops, clk, rst, result.valid && result.ready && !fin_go,
    !result.valid, "result beat repeated")
  `TZB_ASSERT_IMP(a_div_count, clk, rst, state == tzb_pkg::ST_DIV, cnt <= CNT_LAST,
    "divider step count overrun")
  `TZB_ASSERT_NXT(a_store_clamped, clk, rst, state == tzb_pkg::ST_STORE && axis,
    res_y <= TOP_Y, "scaled row beyond screen")

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int RAW_W      = tzb_pkg::RAW_W;
  localparam int TIME_W     = tzb_pkg::TIME_W;
  localparam int CODE_W     = tzb_pkg::CODE_W;
  localparam int SX_W       = tzb_pkg::SX_W;
  localparam int SY_W       = tzb_pkg::SY_W;
  localparam int SETTLE_W   = tzb_pkg::SETTLE_W;
  localparam int CFG_IDX_W  = tzb_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = tzb_pkg::CFG_DATA_W;

  localparam int SCR_W = tzb_pkg::SCREEN_WIDTH_DEF;
  localparam int SCR_H = tzb_pkg::SCREEN_HEIGHT_DEF;
  localparam int BAR_H = tzb_pkg::BAR_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic              touched;
    logic [RAW_W-1:0]  x;
    logic [RAW_W-1:0]  y;
    logic [RAW_W-1:0]  pressure;
    logic [TIME_W-1:0] now;
  } touch_t;

  typedef struct packed {
    logic              fired;
    logic [CODE_W-1:0] pressed;
    logic [CODE_W-1:0] held;
    logic [SX_W-1:0]   sx;
    logic [SY_W-1:0]   sy;
    logic              has_pos;
    logic              finger;
  } report_t;

  logic clk = 1'b0;
  logic rst;

  tzb_sample_if sample_ch ();
  tzb_result_if result_ch ();
  tzb_cfg_if    cfg_ch ();

  touch_zone_button_debouncer DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Register mirror and debouncer state, both at their reset values.
  logic [RAW_W-1:0]    cal_xl_q = tzb_pkg::CAL_LOW_RST;
  logic [RAW_W-1:0]    cal_xh_q = tzb_pkg::CAL_HIGH_RST;
  logic [RAW_W-1:0]    cal_yl_q = tzb_pkg::CAL_LOW_RST;
  logic [RAW_W-1:0]    cal_yh_q = tzb_pkg::CAL_HIGH_RST;
  logic [RAW_W-1:0]    floor_q  = tzb_pkg::FLOOR_RST;
  logic [SETTLE_W-1:0] settle_q = tzb_pkg::SETTLE_RST;

  logic [CODE_W-1:0] held_q   = tzb_pkg::BTN_NONE;
  logic [TIME_W-1:0] change_q = '0;
  logic [CODE_W-1:0] stable_q = tzb_pkg::BTN_NONE;
  logic              fired_q  = 1'b0;
  logic [SX_W-1:0]   pos_x_q  = '0;
  logic [SY_W-1:0]   pos_y_q  = '0;
  logic              known_q  = 1'b0;
  logic              contact_q = 1'b0;

  touch_t  touch_backlog[$];
  report_t expected_reports[$];
  touch_t  touch_current;
  logic    touch_in_flight = 1'b0;
  int      touch_gap = 0;
  int      result_stall = 0;
  int      sample_gap_max = 8;
  int      result_stall_max = 8;
  int      error_count = 0;
  int      cycle_count = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  function automatic int scale_axis(input logic [RAW_W-1:0] raw, lo, hi, input int top);
    longint v;
    if (hi == lo) begin
      v = 0;
    end else begin
      v = (longint'(raw) - longint'(lo)) * longint'(top) / (longint'(hi) - longint'(lo));
    end
    if (v < 0) v = 0;
    if (v > top) v = top;
    return int'(v);
  endfunction

  function automatic logic [CODE_W-1:0] zone_of(input int sx, sy);
    int w;
    w = SCR_W / 4;
    if (sy < SCR_H - BAR_H) return tzb_pkg::BTN_NONE;
    if (sx < w) return tzb_pkg::BTN_LEFT;
    if (sx < 2 * w) return tzb_pkg::BTN_OK;
    if (sx < 3 * w) return tzb_pkg::BTN_RIGHT;
    return tzb_pkg::BTN_LEFT_RIGHT;
  endfunction

  function automatic report_t predict_report(input touch_t s);
    report_t r;
    logic [CODE_W-1:0] code;
    int sx, sy;
    r = '0;
    code = tzb_pkg::BTN_NONE;
    if (s.touched) begin
      contact_q = 1'b1;
      if (s.pressure >= floor_q) begin
        sx = scale_axis(s.x, cal_xl_q, cal_xh_q, SCR_W - 1);
        sy = scale_axis(s.y, cal_yl_q, cal_yh_q, SCR_H - 1);
        pos_x_q = sx[SX_W-1:0];
        pos_y_q = sy[SY_W-1:0];
        known_q = 1'b1;
        code = zone_of(sx, sy);
      end
    end else begin
      contact_q = 1'b0;
    end
    if (code != held_q) begin
      held_q = code;
      change_q = s.now;
      fired_q = 1'b0;
    end
    if (32'(s.now - change_q) > 32'(settle_q)) stable_q = held_q;
    if (stable_q != tzb_pkg::BTN_NONE && !fired_q) begin
      fired_q = 1'b1;
      r.fired = 1'b1;
      r.pressed = stable_q;
    end else if (held_q == tzb_pkg::BTN_NONE) begin
      fired_q = 1'b0;
      stable_q = tzb_pkg::BTN_NONE;
    end
    r.held = held_q;
    r.sx = pos_x_q;
    r.sy = pos_y_q;
    r.has_pos = known_q;
    r.finger = contact_q;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want, got);
    error_count++;
    $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      touch_in_flight = 1'b0;
      touch_gap = 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        expected_reports.push_back(predict_report(touch_current));
        touch_in_flight = 1'b0;
        touch_gap = int'($urandom_range(0, sample_gap_max));
      end
      if (!touch_in_flight) begin
        if (touch_gap > 0) begin
          touch_gap--;
          sample_ch.valid <= 1'b0;
        end else if (touch_backlog.size() > 0) begin
          touch_current = touch_backlog.pop_front();
          sample_ch.valid <= 1'b1;
          sample_ch.panel_touched <= touch_current.touched;
          sample_ch.raw_x <= touch_current.x;
          sample_ch.raw_y <= touch_current.y;
          sample_ch.raw_pressure <= touch_current.pressure;
          sample_ch.now_ms <= touch_current.now;
          touch_in_flight = 1'b1;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    report_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      result_stall = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_reports.size() == 0) begin
          flag_mismatch("unexpected result beat", 0, 1);
        end else begin
          want = expected_reports.pop_front();
          if (result_ch.press_fired !== want.fired)
            flag_mismatch("press_fired", want.fired, result_ch.press_fired);
          if (result_ch.pressed_button !== want.pressed)
            flag_mismatch("pressed_button", want.pressed, result_ch.pressed_button);
          if (result_ch.held_button !== want.held)
            flag_mismatch("held_button", want.held, result_ch.held_button);
          if (result_ch.screen_x !== want.sx)
            flag_mismatch("screen_x", want.sx, result_ch.screen_x);
          if (result_ch.screen_y !== want.sy)
            flag_mismatch("screen_y", want.sy, result_ch.screen_y);
          if (result_ch.has_position !== want.has_pos)
            flag_mismatch("has_position", want.has_pos, result_ch.has_position);
          if (result_ch.finger_down !== want.finger)
            flag_mismatch("finger_down", want.finger, result_ch.finger_down);
        end
        result_stall = int'($urandom_range(0, result_stall_max));
      end
      if (result_stall > 0) begin
        result_stall--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void queue_touch(input logic t, input logic [RAW_W-1:0] x, y, z,
                                      input logic [TIME_W-1:0] now);
    touch_t s;
    s.touched = t;
    s.x = x;
    s.y = y;
    s.pressure = z;
    s.now = now;
    touch_backlog.push_back(s);
  endfunction

  function automatic logic [RAW_W-1:0] raw_at(input logic [RAW_W-1:0] lo, hi, input int pm);
    int v;
    v = int'(lo) + (int'(hi) - int'(lo)) * pm / 1000;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[RAW_W-1:0];
  endfunction

  function automatic void step_clock();
    clock_ms += $urandom_range(0, int'(settle_q) + int'(settle_q) / 2 + 2);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      tzb_pkg::REG_CAL_X_LOW:      cal_xl_q = val[RAW_W-1:0];
      tzb_pkg::REG_CAL_X_HIGH:     cal_xh_q = val[RAW_W-1:0];
      tzb_pkg::REG_CAL_Y_LOW:      cal_yl_q = val[RAW_W-1:0];
      tzb_pkg::REG_CAL_Y_HIGH:     cal_yh_q = val[RAW_W-1:0];
      tzb_pkg::REG_PRESSURE_FLOOR: floor_q = val[RAW_W-1:0];
      tzb_pkg::REG_SETTLE_MS:      settle_q = val;
      default: ;
    endcase
  endtask

  task automatic wait_quiet();
    while (touch_backlog.size() != 0 || touch_in_flight || expected_reports.size() != 0)
      @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // Mostly press sequences in the bottom bar with random hold times, each followed
  // by a release; the rest is unconstrained noise.
  task automatic gen_traffic(input int n);
    int made, hold, zone, k, rel;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) < 7) begin
        zone = int'($urandom_range(1, 4));
        hold = int'($urandom_range(1, 6));
        for (k = 0; k < hold; k++) begin
          if ($urandom_range(0, 4) == 0) zone = int'($urandom_range(1, 4));
          step_clock();
          queue_touch(1'b1,
                      raw_at(cal_xl_q, cal_xh_q,
                             (zone - 1) * 250 + int'($urandom_range(5, 245))),
                      raw_at(cal_yl_q, cal_yh_q, int'($urandom_range(800, 1100))),
                      RAW_W'($urandom_range(int'(floor_q), 4095)), clock_ms);
          made++;
        end
        rel = int'($urandom_range(1, 3));
        for (k = 0; k < rel; k++) begin
          step_clock();
          case ($urandom_range(0, 2))
            0: queue_touch(1'b0, RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
                           clock_ms);
            1: begin
              if (floor_q != 0)
                queue_touch(1'b1, RAW_W'($urandom), RAW_W'($urandom),
                            RAW_W'($urandom_range(0, int'(floor_q) - 1)), clock_ms);
              else
                queue_touch(1'b0, RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
                            clock_ms);
            end
            default: queue_touch(1'b1, RAW_W'($urandom),
                                 raw_at(cal_yl_q, cal_yh_q, int'($urandom_range(0, 700))),
                                 RAW_W'($urandom_range(int'(floor_q), 4095)), clock_ms);
          endcase
          made++;
        end
      end else begin
        if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
        else step_clock();
        queue_touch(1'($urandom_range(0, 1)), RAW_W'($urandom), RAW_W'($urandom),
                    RAW_W'($urandom), clock_ms);
        made++;
      end
    end
  endtask

  task automatic run_phase(input logic [RAW_W-1:0] xl, xh, yl, yh, fl,
                           input logic [SETTLE_W-1:0] st, input int n);
    wait_quiet();
    write_reg(tzb_pkg::REG_CAL_X_LOW, CFG_DATA_W'(xl));
    write_reg(tzb_pkg::REG_CAL_X_HIGH, CFG_DATA_W'(xh));
    write_reg(tzb_pkg::REG_CAL_Y_LOW, CFG_DATA_W'(yl));
    write_reg(tzb_pkg::REG_CAL_Y_HIGH, CFG_DATA_W'(yh));
    write_reg(tzb_pkg::REG_PRESSURE_FLOOR, CFG_DATA_W'(fl));
    write_reg(tzb_pkg::REG_SETTLE_MS, st);
    sample_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
    result_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
    if ($urandom_range(0, 1) == 0) clock_ms = $urandom;
    gen_traffic(n);
  endtask

  initial begin
    logic [RAW_W-1:0] mid;
    int p;
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.panel_touched = 1'b0;
    sample_ch.raw_x = '0;
    sample_ch.raw_y = '0;
    sample_ch.raw_pressure = '0;
    sample_ch.now_ms = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = tzb_pkg::REG_CAL_X_LOW;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at the reset calibration.
    queue_touch(1'b0, 12'd0, 12'd0, 12'd0, 32'd0);
    queue_touch(1'b1, 12'd2000, 12'd2000, 12'd49, 32'd10);
    queue_touch(1'b1, 12'd0, 12'd0, 12'd4095, 32'd20);
    queue_touch(1'b1, 12'd4095, 12'd4095, 12'd50, 32'd30);
    queue_touch(1'b0, 12'd4095, 12'd4095, 12'd4095, 32'd40);
    queue_touch(1'b1, 12'd600, 12'd3600, 12'd1000, 32'd100);
    queue_touch(1'b1, 12'd600, 12'd3600, 12'd1000, 32'd160);
    queue_touch(1'b1, 12'd600, 12'd3600, 12'd1000, 32'd161);
    queue_touch(1'b1, 12'd600, 12'd3600, 12'd1000, 32'd300);
    queue_touch(1'b1, 12'd1600, 12'd3600, 12'd1000, 32'd310);
    queue_touch(1'b1, 12'd1600, 12'd3600, 12'd1000, 32'd400);
    queue_touch(1'b1, 12'd2600, 12'd3600, 12'd1000, 32'd500);
    queue_touch(1'b1, 12'd2600, 12'd3600, 12'd1000, 32'd600);
    queue_touch(1'b0, 12'd2600, 12'd3600, 12'd1000, 32'd700);
    queue_touch(1'b0, 12'd0, 12'd0, 12'd0, 32'd800);
    queue_touch(1'b1, 12'd3500, 12'd3600, 12'd2000, 32'hFFFF_FFF0);
    queue_touch(1'b1, 12'd3500, 12'd3600, 12'd2000, 32'h0000_0020);
    queue_touch(1'b1, 12'd3500, 12'd3600, 12'd2000, 32'h0000_0040);
    queue_touch(1'b1, 12'd3500, 12'd3600, 12'd30, 32'h0000_0050);
    queue_touch(1'b0, 12'd0, 12'd0, 12'd0, 32'hFFFF_FFFF);
    queue_touch(1'b1, 12'd2000, 12'd1000, 12'd100, 32'h0000_0100);
    queue_touch(1'b1, 12'd600, 12'd3600, 12'd4095, 32'h0000_0200);
    queue_touch(1'b1, 12'd600, 12'd3600, 12'd4095, 32'h0000_0300);
    queue_touch(1'b0, 12'd600, 12'd3600, 12'd4095, 32'h0000_0400);
    clock_ms = 32'h0000_1000;

    sample_gap_max = 0;
    result_stall_max = 0;
    wait_quiet();
    write_reg(tzb_pkg::REG_CAL_X_LOW, 16'd0);
    write_reg(tzb_pkg::REG_CAL_X_HIGH, 16'd4095);
    write_reg(tzb_pkg::REG_CAL_Y_LOW, 16'd0);
    write_reg(tzb_pkg::REG_CAL_Y_HIGH, 16'd4095);
    write_reg(tzb_pkg::REG_PRESSURE_FLOOR, 16'd0);
    write_reg(tzb_pkg::REG_SETTLE_MS, 16'd0);
    gen_traffic(200);

    run_phase(12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 16'd65535, 150);
    mid = RAW_W'($urandom);
    run_phase(mid, mid, 12'd100, 12'd3900, RAW_W'($urandom_range(0, 300)),
              SETTLE_W'($urandom_range(0, 300)), 100);
    mid = RAW_W'($urandom);
    run_phase(12'd300, 12'd3700, mid, mid, RAW_W'($urandom_range(0, 300)),
              SETTLE_W'($urandom_range(0, 300)), 100);
    run_phase(12'd3900, 12'd150, 12'd3800, 12'd250, 12'd50, 16'd60, 100);
    for (p = 0; p < 5; p++)
      run_phase(RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
                RAW_W'($urandom_range(0, 400)), SETTLE_W'($urandom_range(0, 300)), 150);
    wait_quiet();

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tzb_pkg.sv
rtl/tzb_sample_if.sv
rtl/tzb_result_if.sv
rtl/tzb_cfg_if.sv
rtl/touch_zone_button_debouncer.sv
verif/testbench.sv
